// ===== design/rbqt_pkg.sv =====
package rbqt_pkg;

  // Fixed field widths and limits.
  localparam int MAX_PEERS     = 64;
  localparam int NUM_SLOTS_DEF = 256;
  localparam int SET_W         = 64;
  localparam int CNT_W         = 7;
  localparam int ID_W          = 6;
  localparam int SLOT_W        = 8;
  localparam int ROUND_W       = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;

  // Message types.
  localparam logic [1:0] OP_SEND  = 2'd0;
  localparam logic [1:0] OP_ECHO  = 2'd1;
  localparam logic [1:0] OP_READY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID    = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] PEER_COUNT_RST = 7'd4;
  localparam logic [ID_W-1:0]  SELF_ID_RST    = 6'd0;

  typedef struct packed {
    logic [1:0]         op;
    logic [ID_W-1:0]    source_id;
    logic [SLOT_W-1:0]  msg_slot;
    logic               fault_flag;
    logic [ROUND_W-1:0] current_round;
    logic [ROUND_W-1:0] submitted_round;
  } in_item_t;

  typedef struct packed {
    logic               send_echo;
    logic               send_ready;
    logic               deliver;
    logic [SLOT_W-1:0]  out_slot;
    logic [ROUND_W-1:0] latency;
    logic [ROUND_W-1:0] delivered_total;
  } out_item_t;

  // Quorum thresholds derived from the peer count.
  typedef struct packed {
    logic [CNT_W-1:0] echo_q;
    logic [CNT_W-1:0] ready_q;
    logic [CNT_W-1:0] deliver_q;
  } quorum_t;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    logic               ignore;
    logic [1:0]         op;
    logic [ID_W-1:0]    source_id;
    logic [SLOT_W-1:0]  msg_slot;
    logic [ROUND_W-1:0] current_round;
    logic [ROUND_W-1:0] submitted_round;
    logic [ID_W-1:0]    self_id;
    quorum_t            quorum;
  } work_item_t;

  // Per-slot record held in the slot memory.
  typedef struct packed {
    logic [SET_W-1:0] echo_set;
    logic [SET_W-1:0] ready_set;
    logic [CNT_W-1:0] echo_count;
    logic [CNT_W-1:0] ready_count;
    logic             delivered;
  } slot_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_FETCH,
    BK_EXEC
  } back_state_t;

  // Thresholds for n peers: t = (n-1)/3, echo (n+t)/2+1, ready t+1, deliver 2t+1.
  // The divide by three is a multiply by 43 and a shift, exact for n-1 below 64.
  function automatic quorum_t calc_quorum(input logic [CNT_W-1:0] peer_count);
    logic [CNT_W-1:0] n;
    logic [12:0]      prod;
    logic [CNT_W-1:0] t;
    logic [CNT_W-1:0] sum;
    quorum_t          q;
    if (peer_count == '0) begin
      n = CNT_W'(1);
    end else if (peer_count > CNT_W'(MAX_PEERS)) begin
      n = CNT_W'(MAX_PEERS);
    end else begin
      n = peer_count;
    end
    prod        = 13'(n - CNT_W'(1)) * 13'd43;
    t           = CNT_W'(prod >> 7);
    sum         = n + t;
    q.echo_q    = (sum >> 1) + CNT_W'(1);
    q.ready_q   = t + CNT_W'(1);
    q.deliver_q = (t << 1) + CNT_W'(1);
    return q;
  endfunction

endpackage

// ===== design/rbqt_ram.sv =====
module rbqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/rbqt_queue.sv =====
module rbqt_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  rbqt_pkg::work_item_t   push_data,
  input  logic                   pop,
  output logic                   pop_valid,
  output rbqt_pkg::work_item_t   pop_data
);
  import rbqt_pkg::*;

  work_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill count of the two-entry queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/rbqt_front.sv =====
module rbqt_front #(
  parameter int NUM_SLOTS = rbqt_pkg::NUM_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rbqt_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [rbqt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbqt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                clearing,
  output logic                                push_valid,
  input  logic                                push_ready,
  output rbqt_pkg::work_item_t                push_data
);
  import rbqt_pkg::*;

  logic [CNT_W-1:0] peer_count;
  logic [ID_W-1:0]  self_id;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      peer_count <= PEER_COUNT_RST;
      self_id    <= SELF_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PEER_COUNT: peer_count <= cfg_data;
        CFG_SELF_ID:    self_id    <= cfg_data[ID_W-1:0];
        default:        ;
      endcase
    end
  end

  // Items are held off while the slot memory is being cleared.
  assign in_ready   = push_ready && !clearing;
  assign push_valid = in_valid && !clearing;

  // Classify the item: faulty messages and slots past the memory are ignored.
  always_comb begin
    push_data.ignore          = in_data.fault_flag ||
                                (32'(in_data.msg_slot) >= 32'(NUM_SLOTS));
    push_data.op              = in_data.op;
    push_data.source_id       = in_data.source_id;
    push_data.msg_slot        = in_data.msg_slot;
    push_data.current_round   = in_data.current_round;
    push_data.submitted_round = in_data.submitted_round;
    push_data.self_id         = self_id;
    push_data.quorum          = calc_quorum(peer_count);
  end

endmodule

// ===== design/rbqt_back.sv =====
module rbqt_back #(
  parameter int NUM_SLOTS = rbqt_pkg::NUM_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  input  rbqt_pkg::work_item_t   pop_data,
  output logic                   pop,
  output logic                   clearing,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rbqt_pkg::out_item_t    out_data
);
  import rbqt_pkg::*;

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SLOTS - 1);

  back_state_t      state;
  back_state_t      state_next;
  logic [AW-1:0]    clr_addr;
  work_item_t       cur;
  logic [ROUND_W-1:0] delivered_cnt;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  slot_state_t      wr_data;
  slot_state_t      rd_data;

  slot_state_t      upd;
  out_item_t        result;
  logic [ROUND_W-1:0] delivered_cnt_next;

  rbqt_ram #(
    .WIDTH ($bits(slot_state_t)),
    .DEPTH (NUM_SLOTS),
    .AW    (AW)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Slot update: add the sender, test the quorums, add this peer, then test delivery.
  always_comb begin
    logic [SET_W-1:0] sbit;
    logic [SET_W-1:0] mbit;
    logic             echo_add;
    logic             ready_add;
    logic             ec;
    logic             rc;
    logic             do_echo;
    logic             do_ready;
    logic             do_deliver;
    slot_state_t      s;
    sbit = SET_W'(1) << cur.source_id;
    mbit = SET_W'(1) << cur.self_id;
    s    = rd_data;

    echo_add  = (cur.op == OP_ECHO) && !s.echo_set[cur.source_id];
    ready_add = (cur.op == OP_READY) && !s.ready_set[cur.source_id];
    if (echo_add) begin
      s.echo_set   = s.echo_set | sbit;
      s.echo_count = s.echo_count + CNT_W'(1);
    end
    if (ready_add) begin
      s.ready_set   = s.ready_set | sbit;
      s.ready_count = s.ready_count + CNT_W'(1);
    end

    ec = s.echo_count >= cur.quorum.echo_q;
    rc = s.ready_count >= cur.quorum.ready_q;

    do_echo = ((cur.op == OP_SEND) || ec || rc) && !s.echo_set[cur.self_id];
    if (do_echo) begin
      s.echo_set   = s.echo_set | mbit;
      s.echo_count = s.echo_count + CNT_W'(1);
    end
    do_ready = (ec || rc) && !s.ready_set[cur.self_id];
    if (do_ready) begin
      s.ready_set   = s.ready_set | mbit;
      s.ready_count = s.ready_count + CNT_W'(1);
    end
    do_deliver = (s.ready_count >= cur.quorum.deliver_q) && !s.delivered;
    if (do_deliver) begin
      s.delivered = 1'b1;
    end
    upd = s;

    delivered_cnt_next = delivered_cnt;
    if (do_deliver && !cur.ignore && (delivered_cnt != '1)) begin
      delivered_cnt_next = delivered_cnt + ROUND_W'(1);
    end

    result.send_echo       = do_echo && !cur.ignore;
    result.send_ready      = do_ready && !cur.ignore;
    result.deliver         = do_deliver && !cur.ignore;
    result.out_slot        = cur.msg_slot;
    result.latency         = '0;
    if (result.deliver && (cur.current_round > cur.submitted_round)) begin
      result.latency = cur.current_round - cur.submitted_round;
    end
    result.delivered_total = delivered_cnt_next;
  end

  // Sequencer: clear sweep after reset, then fetch and execute per item.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = clr_addr;
    wr_data    = '0;
    case (state)
      BK_CLEAR: begin
        wr_en = 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = BK_FETCH;
        end
      end
      BK_FETCH: begin
        if (pop_valid && (!out_valid || out_ready)) begin
          pop        = 1'b1;
          rd_en      = 1'b1;
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        wr_en      = !cur.ignore;
        wr_addr    = AW'(cur.msg_slot);
        wr_data    = upd;
        state_next = BK_FETCH;
      end
      default: begin
        state_next = BK_CLEAR;
      end
    endcase
  end

  assign rd_addr  = AW'(pop_data.msg_slot);
  assign clearing = (state == BK_CLEAR);

  // State register, sweep address and delivery counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_CLEAR;
      clr_addr      <= '0;
      delivered_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == BK_EXEC) begin
        delivered_cnt <= delivered_cnt_next;
      end
    end
  end

  // Item being executed.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == BK_EXEC) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_EXEC) begin
      out_data <= result;
    end
  end

endmodule

// ===== design/reliable_broadcast_quorum_tracker_unit.sv =====
// Quorum tracker for one peer of reliable broadcast.
// Input channel in_valid/in_ready/in_data carries one received message per
// item; output channel out_valid/out_ready/out_data returns exactly one result
// item per message, in order. Configuration (peer count, own identifier) is
// written through cfg_we/cfg_index/cfg_data; the user must write it only while
// the block is idle, as the block itself does not enforce this. An item is
// classified on entry and placed in a two-entry queue. The back end then reads
// the slot record from the slot memory and writes the updated record and the
// result in the following cycle, so it takes a new item only after the last
// one is written back, owing to the read-modify-write of the slot memory behind
// its registered read port. After reset the slot memory is swept to zero, one
// slot per cycle; in_ready stays low during that sweep. When the receiver
// stalls, the result waits in the output register and up to two further items
// are taken into the queue before in_ready drops.
module reliable_broadcast_quorum_tracker_unit #(
  parameter int NUM_SLOTS = rbqt_pkg::NUM_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rbqt_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rbqt_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [rbqt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbqt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rbqt_pkg::*;

  logic       clearing;
  logic       push_valid;
  logic       push_ready;
  work_item_t push_data;
  logic       pop;
  logic       pop_valid;
  work_item_t pop_data;

  rbqt_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rbqt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  rbqt_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
